[sv/osbr_pkg.sv]
// Package for the oversampled serial byte receiver.
// Holds the word, result and configuration types and the register index codes.
// No dependencies.
package osbr_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_WAIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_WAIT   = 1'd1;

    localparam logic [7:0] START_WAIT_RESET = 8'd5;
    localparam logic [7:0] BIT_WAIT_RESET   = 8'd12;
    localparam logic [7:0] NO_DATA          = 8'hFF;

    typedef struct packed {
        logic line_bit;
        logic read_request;
    } tick_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       byte_ready;
    } result_t;

    typedef struct packed {
        logic [7:0] start_wait;
        logic [7:0] bit_wait;
    } cfg_t;

endpackage

[sv/osbr_frame.sv]
// Frame state machine of the oversampled serial byte receiver.
// Advances one oversampling tick per step and forms that tick's result.
// Depends on osbr_pkg.
module osbr_frame #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  osbr_pkg::tick_t  tick,
    input  osbr_pkg::cfg_t   cfg,
    output osbr_pkg::result_t result
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_CLEAR = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_SAMP  = 3'd4;
    localparam logic [2:0] PH_LATCH = 3'd5;

    localparam logic [3:0] BITS_LAST = 4'(DATA_BITS);

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [3:0] bits_taken_reg;
    logic [3:0] bits_taken_next;
    logic [7:0] tick_count_reg;
    logic [7:0] tick_count_next;
    logic [7:0] shift_byte_reg;
    logic [7:0] shift_byte_next;
    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;
    logic       ready_flag_reg;
    logic       ready_flag_next;
    logic [7:0] tick_inc;
    logic [7:0] data;

    assign tick_inc = tick_count_reg + 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bits_taken_next = bits_taken_reg;
        tick_count_next = tick_count_reg;
        shift_byte_next = shift_byte_reg;
        held_byte_next  = held_byte_reg;
        ready_flag_next = ready_flag_reg;
        data            = osbr_pkg::NO_DATA;

        if (tick.read_request && ready_flag_reg)
        begin
            data            = held_byte_reg;
            ready_flag_next = 1'b0;
        end

        unique case (phase_reg)
            PH_START:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= cfg.start_wait)
                begin
                    phase_next = PH_CLEAR;
                end
            end
            PH_CLEAR:
            begin
                tick_count_next = 8'd0;
                bits_taken_next = 4'd0;
                phase_next      = PH_WAIT;
            end
            PH_WAIT:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= cfg.bit_wait)
                begin
                    phase_next = (bits_taken_reg < BITS_LAST) ? PH_SAMP : PH_LATCH;
                end
            end
            PH_SAMP:
            begin
                bits_taken_next = bits_taken_reg + 4'd1;
                tick_count_next = 8'd0;
                shift_byte_next = {tick.line_bit, shift_byte_reg[7:1]};
                phase_next      = PH_WAIT;
            end
            PH_LATCH:
            begin
                held_byte_next  = shift_byte_reg;
                ready_flag_next = 1'b1;
                phase_next      = PH_IDLE;
            end
            default:
            begin
                tick_count_next = 8'd0;
                phase_next      = tick.line_bit ? PH_IDLE : PH_START;
            end
        endcase
    end

    assign result.read_data  = data;
    assign result.byte_ready = ready_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bits_taken_reg <= 4'd0;
            tick_count_reg <= 8'd0;
            shift_byte_reg <= 8'd0;
            held_byte_reg  <= 8'd0;
            ready_flag_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bits_taken_reg <= bits_taken_next;
            tick_count_reg <= tick_count_next;
            shift_byte_reg <= shift_byte_next;
            held_byte_reg  <= held_byte_next;
            ready_flag_reg <= ready_flag_next;
        end
    end

`ifndef SYNTH
    a_latch_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_LATCH) |=> ready_flag_reg)
        else $error("ready flag not set after latching a byte");

    a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bits_taken_reg <= BITS_LAST)
        else $error("more data bits taken than the frame holds");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(ready_flag_reg) && $stable(held_byte_reg)))
        else $error("frame state changed without a tick");

    a_read_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (step && tick.read_request && phase_reg != PH_LATCH) |=> !ready_flag_reg)
        else $error("read left the ready flag set");
`endif

endmodule

[sv/oversampled_serial_byte_receiver.sv]
// Oversampled serial byte receiver: input word register, frame state machine, result register.
// One result word per tick word. Each tick enters and leaves in one pass through the logic.
// Depends on osbr_pkg and osbr_frame.

// The block takes one oversampling tick word per cycle unless in_stall holds it, and returns
// one result word per tick through the input word and result registers; the frame state
// machine updates once per tick. The start delay and each bit delay last start_wait and
// bit_wait ticks, zero acting as one. Data bits enter at the top of the byte, so with fewer
// than eight data bits the received bits sit in the upper bits. No stop bit is checked.
module oversampled_serial_byte_receiver #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               line_bit,
    input  logic                               read_request,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         read_data,
    output logic                               byte_ready,
    input  logic                               cfg_write,
    input  logic [osbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [osbr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    osbr_pkg::tick_t   tick_reg;
    logic              tick_valid_reg;
    osbr_pkg::result_t result_reg;
    osbr_pkg::result_t result_next;
    logic              out_valid_reg;
    osbr_pkg::cfg_t    cfg_reg;
    logic              out_free;
    logic              step;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = tick_valid_reg && out_free;
    assign in_stall = tick_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_wait <= osbr_pkg::START_WAIT_RESET;
            cfg_reg.bit_wait   <= osbr_pkg::BIT_WAIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                osbr_pkg::CFG_START_WAIT: cfg_reg.start_wait <= cfg_data;
                osbr_pkg::CFG_BIT_WAIT:   cfg_reg.bit_wait   <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                tick_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            tick_reg.line_bit     <= line_bit;
            tick_reg.read_request <= read_request;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    osbr_frame #(
        .DATA_BITS (DATA_BITS)
    ) u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (tick_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    assign out_valid  = out_valid_reg;
    assign read_data  = result_reg.read_data;
    assign byte_ready = result_reg.byte_ready;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for oversampled_serial_byte_receiver.
// Carries its own frame receiver model, a bursty tick driver and a stalling result monitor.
// Depends on osbr_pkg and the receiver RTL.
module tb;

    localparam int unsigned FRAME_BITS   = 8;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_WORDS  = 70;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_CLEAR  = 3'd2;
    localparam logic [2:0] PH_WAIT   = 3'd3;
    localparam logic [2:0] PH_SAMPLE = 3'd4;
    localparam logic [2:0] PH_LATCH  = 3'd5;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             in_valid     = 1'b0;
    logic                             in_stall;
    logic                             line_bit     = 1'b1;
    logic                             read_request = 1'b0;
    logic                             out_valid;
    logic                             out_stall    = 1'b0;
    logic [7:0]                       read_data;
    logic                             byte_ready;
    logic                             cfg_write    = 1'b0;
    logic [osbr_pkg::CFG_INDEX_W-1:0] cfg_index    = osbr_pkg::CFG_START_WAIT;
    logic [osbr_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    logic [2:0] rx_phase      = PH_IDLE;
    logic [3:0] rx_bits       = '0;
    logic [7:0] rx_ticks      = '0;
    logic [7:0] rx_shift      = '0;
    logic [7:0] rx_held       = '0;
    logic       rx_ready      = 1'b0;
    logic [7:0] rx_start_wait = osbr_pkg::START_WAIT_RESET;
    logic [7:0] rx_bit_wait   = osbr_pkg::BIT_WAIT_RESET;

    osbr_pkg::tick_t   line_ticks[$];
    osbr_pkg::result_t rx_results_due[$];
    logic              word_taken  = 1'b0;
    int unsigned       mismatches  = 0;
    int unsigned       send_burst  = 0;
    int unsigned       send_gap    = 0;
    int unsigned       stall_mode  = 0;
    int unsigned       mode_left   = 0;
    int unsigned       hold_left   = 0;
    int unsigned       hold_asks   = 0;
    int unsigned       holds_done  = 0;

    oversampled_serial_byte_receiver #(
        .DATA_BITS(FRAME_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .line_bit    (line_bit),
        .read_request(read_request),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .byte_ready  (byte_ready),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic osbr_pkg::result_t receive_tick(input osbr_pkg::tick_t word);
        osbr_pkg::result_t res;
        res.read_data = osbr_pkg::NO_DATA;
        if (word.read_request && rx_ready)
        begin
            res.read_data = rx_held;
            rx_ready = 1'b0;
        end
        case (rx_phase)
            PH_START:
            begin
                rx_ticks = rx_ticks + 8'd1;
                if (rx_ticks >= rx_start_wait)
                    rx_phase = PH_CLEAR;
            end
            PH_CLEAR:
            begin
                rx_ticks = '0;
                rx_bits  = '0;
                rx_phase = PH_WAIT;
            end
            PH_WAIT:
            begin
                rx_ticks = rx_ticks + 8'd1;
                if (rx_ticks >= rx_bit_wait)
                    rx_phase = (rx_bits < FRAME_BITS) ? PH_SAMPLE : PH_LATCH;
            end
            PH_SAMPLE:
            begin
                rx_bits  = rx_bits + 4'd1;
                rx_ticks = '0;
                rx_shift = {word.line_bit, rx_shift[7:1]};
                rx_phase = PH_WAIT;
            end
            PH_LATCH:
            begin
                rx_held  = rx_shift;
                rx_ready = 1'b1;
                rx_phase = PH_IDLE;
            end
            default:
            begin
                rx_ticks = '0;
                rx_phase = word.line_bit ? PH_IDLE : PH_START;
            end
        endcase
        res.byte_ready = rx_ready;
        return res;
    endfunction

    task automatic push_tick(input logic level, input int unsigned read_pct);
        osbr_pkg::tick_t word;
        word.line_bit     = level;
        word.read_request = ($urandom_range(0, 99) < read_pct);
        line_ticks.push_back(word);
    endtask

    task automatic queue_frame(input logic [7:0] value, input int unsigned bit_len,
                               input int unsigned lead_len, input int unsigned stop_len,
                               input int unsigned read_pct);
        for (int unsigned i = 0; i < lead_len; i++)
            push_tick(1'b1, read_pct);
        for (int unsigned i = 0; i < bit_len; i++)
            push_tick(1'b0, read_pct);
        for (int unsigned b = 0; b < FRAME_BITS; b++)
            for (int unsigned i = 0; i < bit_len; i++)
                push_tick(value[b], read_pct);
        for (int unsigned i = 0; i < stop_len; i++)
            push_tick(1'b1, read_pct);
    endtask

    task automatic queue_random_phase(input int unsigned word_goal);
        int unsigned period;
        int unsigned bit_len;
        int unsigned read_pct;
        int unsigned pick;
        period = ((rx_bit_wait == 8'd0) ? 1 : rx_bit_wait) + 1;
        while (line_ticks.size() < word_goal)
        begin
            case ($urandom_range(0, 3))
                0:       read_pct = 0;
                1:       read_pct = 5;
                2:       read_pct = 25;
                default: read_pct = 60;
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                bit_len = period;
                if (pick == 0)
                    bit_len = period + 1;
                else if (pick == 1 && period > 2)
                    bit_len = period - 1;
                queue_frame(8'($urandom_range(0, 255)), bit_len, $urandom_range(0, 4),
                            $urandom_range(1, 2 * period), read_pct);
            end
            else
            begin
                push_tick(1'b0, read_pct);
                repeat ($urandom_range(1, 10 * period))
                    push_tick(1'($urandom_range(0, 1)), read_pct);
            end
        end
    endtask

    task automatic write_reg(input logic [osbr_pkg::CFG_INDEX_W-1:0] index,
                             input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (index == osbr_pkg::CFG_START_WAIT)
            rx_start_wait = value;
        else
            rx_bit_wait = value;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (line_ticks.size() != 0 || in_valid || rx_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin : tick_driver
        osbr_pkg::tick_t word;
        if (rst_n && (!in_valid || word_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (line_ticks.size() > 0)
            begin
                word = line_ticks.pop_front();
                in_valid     <= 1'b1;
                line_bit     <= word.line_bit;
                read_request <= word.read_request;
                if (send_burst <= 1)
                begin
                    send_burst <= $urandom_range(1, 40);
                    send_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    send_burst <= send_burst - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != holds_done)
        begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(5, 60);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_monitor
        osbr_pkg::tick_t   word;
        osbr_pkg::result_t want;
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                word.line_bit     = line_bit;
                word.read_request = read_request;
                rx_results_due.push_back(receive_tick(word));
            end
            if (out_valid && !out_stall)
            begin
                if (rx_results_due.size() == 0)
                begin
                    $display("%0t: unexpected word, read_data %0d byte_ready %0d",
                             $time, read_data, byte_ready);
                    mismatches++;
                end
                else
                begin
                    want = rx_results_due.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %0d, got %0d",
                                 $time, want.read_data, read_data);
                        mismatches++;
                    end
                    if (byte_ready !== want.byte_ready)
                    begin
                        $display("%0t: byte_ready expected %0d, got %0d",
                                 $time, want.byte_ready, byte_ready);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb failed");
        $finish;
    end

    initial
    begin
        logic [7:0] bit_wait;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reads with nothing received yet, then a short frame left unread before two reads.
        push_tick(1'b1, 100);
        push_tick(1'b1, 100);
        push_tick(1'b1, 0);
        wait_idle();
        write_reg(osbr_pkg::CFG_START_WAIT, 8'd0);
        write_reg(osbr_pkg::CFG_BIT_WAIT, 8'd0);
        queue_frame(8'hA5, 2, 0, 3, 0);
        push_tick(1'b1, 100);
        push_tick(1'b1, 100);
        wait_idle();

        write_reg(osbr_pkg::CFG_START_WAIT, osbr_pkg::START_WAIT_RESET);
        write_reg(osbr_pkg::CFG_BIT_WAIT, osbr_pkg::BIT_WAIT_RESET);
        queue_random_phase(PHASE_WORDS);
        wait_idle();

        // Longest delays: run through the full start delay and one full bit delay.
        write_reg(osbr_pkg::CFG_START_WAIT, 8'hFF);
        write_reg(osbr_pkg::CFG_BIT_WAIT, 8'hFF);
        queue_frame(8'($urandom_range(0, 255)), 40, 1, 40, 10);
        repeat (150)
            push_tick(1'b1, 10);
        wait_idle();

        for (int unsigned phase_no = 0; phase_no < 11; phase_no++)
        begin
            case ($urandom_range(0, 9))
                0:       bit_wait = 8'd0;
                8, 9:    bit_wait = 8'($urandom_range(6, 24));
                default: bit_wait = 8'($urandom_range(1, 5));
            endcase
            write_reg(osbr_pkg::CFG_BIT_WAIT, bit_wait);
            write_reg(osbr_pkg::CFG_START_WAIT, 8'($urandom_range(0, bit_wait)));
            queue_random_phase(PHASE_WORDS);
            if (phase_no == 2)
                hold_asks = hold_asks + 1;
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
